// File: src/tvr_pkg.sv
// Shared types, constants and helpers for the trilinear volume resampler.
// No dependencies; every other file imports this package.
package tvr_pkg;

  localparam int MAX_DIM    = 32;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int SAMPLE_W   = 32;
  localparam int QUERY_W    = 12;
  localparam int SRC_W      = 6;
  localparam int TGT_W      = 13;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = DIM_W + FRAC_W;
  localparam int PROD_W     = QUERY_W + DIM_W;
  localparam int DIVIDEND_W = PROD_W + FRAC_W;
  localparam int ADDR_W     = 3 * DIM_W;
  localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int RESET_SIZE = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DEPTH  = 3'd5;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ERROR,
    CMD_QUERY
  } cmd_kind_t;

  // Command passed from front to back through the queue
  typedef struct packed {
    cmd_kind_t                   kind;
    logic [DIM_W-1:0]            x0;
    logic [DIM_W-1:0]            y0;
    logic [DIM_W-1:0]            z0;
    logic [DIM_W-1:0]            x1;
    logic [DIM_W-1:0]            y1;
    logic [DIM_W-1:0]            z1;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fy;
    logic [FRAC_W-1:0]           fz;
    logic signed [SAMPLE_W-1:0]  sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Effective source size minus one: zero counts as one, clamp to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_m1(input logic [SRC_W-1:0] s);
    logic [DIM_W-1:0] r;
    if (s == '0) begin
      r = '0;
    end else if (s > SRC_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(s - SRC_W'(1));
    end
    return r;
  endfunction

endpackage

// File: src/tvr_in_if.sv
// Input request channel: valid/ready plus write and query payload.
// Depends on tvr_pkg.
interface tvr_in_if;
  import tvr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [DIM_W-1:0]            load_x;
  logic [DIM_W-1:0]            load_y;
  logic [DIM_W-1:0]            load_z;
  logic signed [SAMPLE_W-1:0]  sample_value;
  logic [QUERY_W-1:0]          query_x;
  logic [QUERY_W-1:0]          query_y;
  logic [QUERY_W-1:0]          query_z;

  modport source(output valid, operation, load_x, load_y, load_z, sample_value,
                 query_x, query_y, query_z, input ready);
  modport sink(input valid, operation, load_x, load_y, load_z, sample_value,
               query_x, query_y, query_z, output ready);
endinterface

// File: src/tvr_out_if.sv
// Result channel: valid/ready plus interpolated value and error flag.
// Depends on tvr_pkg.
interface tvr_out_if;
  import tvr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  interpolated_value;
  logic                        range_error;

  modport source(output valid, interpolated_value, range_error, input ready);
  modport sink(input valid, interpolated_value, range_error, output ready);
endinterface

// File: src/tvr_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on tvr_pkg.
interface tvr_cfg_if;
  import tvr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/trilinear_volume_resampler_unit.sv
// Top level of the trilinear volume resampler: front, command queue, back.
// Depends on tvr_pkg, the channel interfaces, tvr_front, tvr_cmd_q, tvr_back.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | operation, load_x/y/z, sample_value, query_x/y/z
//   out_ch   | out | interpolated_value, range_error
//   cfg_ch   | in  | index, data (register write)
//
// A sample write is stored in the volume memory as the back end pops it. A
// query in range is divided in the front (21-step bit-serial divide, three
// axes in parallel, one state to see it done, one to push) and then worked in
// the back (pop, read eight corners one at a time from the volume memory,
// seven blends on one shared multiplier, load the result register).
// Out-of-range queries skip the divide and the blends.
// Reset clears control state only; the volume memory is undefined until
// written. Either side may stall; the two-entry queue decouples them.
module trilinear_volume_resampler_unit (
  input  logic      clk,
  input  logic      rst_n,
  tvr_in_if.sink    in_ch,
  tvr_out_if.source out_ch,
  tvr_cfg_if.sink   cfg_ch
);
  import tvr_pkg::*;

  logic     q_push;
  logic     q_pop;
  cmd_t     q_data;
  cmd_t     q_head;
  q_stat_t  q_stat;

  tvr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_data)
  );

  tvr_cmd_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  tvr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // Never push a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.range_error) |-> (out_ch.interpolated_value == '0))
    else $error("range error with nonzero value");
endmodule

// File: src/tvr_div.sv
// Restoring divider, one quotient bit per cycle, for one axis mapping.
// Depends on tvr_pkg.
module tvr_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tvr_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [tvr_pkg::TGT_W-1:0]        divisor,
  output logic                             busy,
  output logic [tvr_pkg::POS_W-1:0]        quot
);
  import tvr_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TGT_W-1:0]  rem_r;
  logic [TGT_W-1:0]  div_r;
  logic [POS_W-1:0]  sh_r;
  logic [TGT_W:0]    trial;
  logic              ge;

  // Shift in next dividend bit and compare with divisor
  always_comb begin
    trial = {rem_r, sh_r[POS_W-1]};
    ge    = trial >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(POS_W);
      rem_r  <= TGT_W'(dividend[DIVIDEND_W-1:POS_W]);
      sh_r   <= dividend[POS_W-1:0];
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? TGT_W'(trial - {1'b0, div_r}) : TGT_W'(trial);
      sh_r   <= {sh_r[POS_W-2:0], ge};
      cnt_r  <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = sh_r;
endmodule

// File: src/tvr_cmd_q.sv
// Two-entry command queue between front and back.
// Depends on tvr_pkg.
module tvr_cmd_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tvr_pkg::cmd_t     push_data,
  input  logic              pop,
  output tvr_pkg::cmd_t     head,
  output tvr_pkg::q_stat_t  stat
);
  import tvr_pkg::*;

  cmd_t        ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
endmodule

// File: src/tvr_front.sv
// Front end: config registers, request classification, axis mapping dividers.
// Depends on tvr_pkg, tvr_in_if, tvr_cfg_if, tvr_div.
module tvr_front (
  input  logic              clk,
  input  logic              rst_n,
  tvr_in_if.sink            in_ch,
  tvr_cfg_if.sink           cfg_ch,
  input  tvr_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output tvr_pkg::cmd_t     q_data
);
  import tvr_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic [SRC_W-1:0]   src_r [3];
  logic [TGT_W-1:0]   tgt_r [3];
  logic [QUERY_W-1:0] qidx [3];
  logic [DIM_W-1:0]   sm1 [3];
  logic [2:0]         oob;
  logic [2:0]         busy;
  logic [POS_W-1:0]   quot [3];
  logic [DIM_W-1:0]   lo [3];
  logic [DIM_W-1:0]   hi [3];
  logic [FRAC_W-1:0]  frac [3];
  logic               accept;
  logic               start;

  assign qidx[0] = in_ch.query_x;
  assign qidx[1] = in_ch.query_y;
  assign qidx[2] = in_ch.query_z;

  // Per-axis range check, divider and corner selection
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [PROD_W-1:0]      prod;
    logic [DIVIDEND_W-1:0]  dvd;
    logic [POS_W-1:0]       pos;
    logic [DIM_W-1:0]       base;

    assign sm1[a] = eff_m1(src_r[a]);
    assign oob[a] = {1'b0, qidx[a]} >= tgt_r[a];
    assign prod   = PROD_W'(qidx[a]) * PROD_W'(sm1[a]);
    assign dvd    = {prod, FRAC_W'(0)};

    tvr_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (start),
      .dividend (dvd),
      .divisor  (tgt_r[a] - TGT_W'(1)),
      .busy     (busy[a]),
      .quot     (quot[a])
    );

    // Single-point target axis maps to zero
    assign pos     = (tgt_r[a] <= TGT_W'(1)) ? '0 : quot[a];
    assign base    = pos[POS_W-1:FRAC_W];
    assign lo[a]   = (base > sm1[a]) ? sm1[a] : base;
    assign hi[a]   = (lo[a] < sm1[a]) ? lo[a] + DIM_W'(1) : sm1[a];
    assign frac[a] = pos[FRAC_W-1:0];
  end

  assign in_ch.ready  = (state_r == F_IDLE) && !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign start        = accept && (in_ch.operation == OP_QUERY) && !(|oob);

  // Build the queued command
  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    if (state_r == F_PUSH) begin
      q_push      = !q_stat.full;
      q_data.kind = CMD_QUERY;
      q_data.x0   = lo[0];
      q_data.y0   = lo[1];
      q_data.z0   = lo[2];
      q_data.x1   = hi[0];
      q_data.y1   = hi[1];
      q_data.z1   = hi[2];
      q_data.fx   = frac[0];
      q_data.fy   = frac[1];
      q_data.fz   = frac[2];
    end else if (accept && in_ch.operation == OP_WRITE) begin
      q_push        = 1'b1;
      q_data.kind   = CMD_WRITE;
      q_data.x0     = in_ch.load_x;
      q_data.y0     = in_ch.load_y;
      q_data.z0     = in_ch.load_z;
      q_data.sample = in_ch.sample_value;
    end else if (accept && (|oob)) begin
      q_push      = 1'b1;
      q_data.kind = CMD_ERROR;
    end
  end

  // Query sequence: accept, divide, push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          if (!(|busy)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        src_r[i] <= SRC_W'(RESET_SIZE);
        tgt_r[i] <= TGT_W'(RESET_SIZE);
      end
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_SOURCE_WIDTH:  src_r[0] <= cfg_ch.data[SRC_W-1:0];
        REG_SOURCE_HEIGHT: src_r[1] <= cfg_ch.data[SRC_W-1:0];
        REG_SOURCE_DEPTH:  src_r[2] <= cfg_ch.data[SRC_W-1:0];
        REG_TARGET_WIDTH:  tgt_r[0] <= cfg_ch.data[TGT_W-1:0];
        REG_TARGET_HEIGHT: tgt_r[1] <= cfg_ch.data[TGT_W-1:0];
        REG_TARGET_DEPTH:  tgt_r[2] <= cfg_ch.data[TGT_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// File: src/tvr_back.sv
// Back end: volume memory, corner fetch, shared lerp unit, result register.
// Depends on tvr_pkg, tvr_out_if.
module tvr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tvr_pkg::cmd_t     head,
  input  tvr_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  tvr_out_if.source         out_ch
);
  import tvr_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int MUL_W  = DIFF_W + FRAC_W + 1;

  typedef enum logic [2:0] {B_IDLE, B_READ, B_MUL, B_ADD, B_EMIT} bstate_t;

  bstate_t                     state_r;
  cmd_t                        cmd_r;
  logic [3:0]                  cnt_r;
  logic [3:0]                  n_r;
  logic [2:0]                  step_r;
  logic signed [SAMPLE_W-1:0]  c_r [8];
  logic signed [SAMPLE_W-1:0]  a_r;
  logic signed [SAMPLE_W-1:0]  res_r;
  logic signed [MUL_W-1:0]     prod_r;
  logic signed [SAMPLE_W-1:0]  mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0]  rdata_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_value_r;
  logic                        out_err_r;
  logic                        out_free;
  logic                        emit_err;
  logic                        emit_res;
  logic                        mem_we;
  logic [ADDR_W-1:0]           rd_addr;
  logic [FRAC_W-1:0]           f_sel;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [SAMPLE_W-1:0]  lerp_res;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit_err = (state_r == B_IDLE) && !q_stat.empty && (head.kind == CMD_ERROR) &&
                    out_free;
  assign emit_res = (state_r == B_EMIT) && out_free;

  // Corner address: bit 0 picks x, bit 1 y, bit 2 z
  always_comb begin
    rd_addr = {cnt_r[2] ? cmd_r.z1 : cmd_r.z0,
               cnt_r[1] ? cmd_r.y1 : cmd_r.y0,
               cnt_r[0] ? cmd_r.x1 : cmd_r.x0};
  end

  // Pop rules and memory write
  always_comb begin
    q_pop  = 1'b0;
    mem_we = 1'b0;
    if (state_r == B_IDLE && !q_stat.empty) begin
      unique case (head.kind)
        CMD_WRITE: begin
          q_pop  = 1'b1;
          mem_we = 1'b1;
        end
        CMD_ERROR: q_pop = out_free;
        CMD_QUERY: q_pop = 1'b1;
        default:   q_pop = 1'b1;
      endcase
    end
  end

  // Lerp operands: x first, then y, then z
  always_comb begin
    priority if (step_r < 3'd4) begin
      f_sel = cmd_r.fx;
    end else if (step_r < 3'd6) begin
      f_sel = cmd_r.fy;
    end else begin
      f_sel = cmd_r.fz;
    end
    diff     = DIFF_W'(c_r[1]) - DIFF_W'(c_r[0]);
    lerp_res = a_r + prod_r[FRAC_W+SAMPLE_W-1:FRAC_W];
  end

  // Volume store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{head.z0, head.y0, head.x0}] <= head.sample;
    end
    rdata_r <= mem[rd_addr];
  end

  // Load the result register; drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_err || emit_res) begin
      out_valid_r <= 1'b1;
      out_value_r <= emit_err ? '0 : res_r;
      out_err_r   <= emit_err;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      step_r      <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_stat.empty && head.kind == CMD_QUERY) begin
            cmd_r   <= head;
            cnt_r   <= '0;
            state_r <= B_READ;
          end
        end
        B_READ: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r != 4'd0) begin
            c_r[3'(cnt_r - 4'd1)] <= rdata_r;
          end
          if (cnt_r == 4'd8) begin
            n_r     <= 4'd8;
            step_r  <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r  <= diff * $signed({1'b0, f_sel});
          a_r     <= c_r[0];
          state_r <= B_ADD;
        end
        B_ADD: begin
          if (step_r == 3'd6) begin
            res_r   <= lerp_res;
            state_r <= B_EMIT;
          end else begin
            // Drop the consumed pair, append the blend
            for (int i = 0; i < 6; i++) begin
              if (4'(i) != n_r - 4'd2) begin
                c_r[i] <= c_r[i+2];
              end
            end
            c_r[3'(n_r - 4'd2)] <= lerp_res;
            n_r     <= n_r - 4'd1;
            step_r  <= step_r + 3'd1;
            state_r <= B_MUL;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.interpolated_value = out_value_r;
  assign out_ch.range_error        = out_err_r;
endmodule
